/* rtl/core/grid_cell_occupancy_map_unit_assert.svh */
// Assertion macros for the grid cell occupancy map unit.
`ifndef GRID_CELL_OCCUPANCY_MAP_UNIT_ASSERT_SVH
`define GRID_CELL_OCCUPANCY_MAP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GCOM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GCOM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gcom_pkg.sv */
// Shared types and constants for the grid cell occupancy map unit.
`timescale 1ns / 1ps

package gcom_pkg;

    localparam int MAX_ROWS      = 16;
    localparam int MAX_COLS      = 16;
    localparam int COORD_BITS    = 12;
    localparam int CELL_COUNT    = MAX_ROWS * MAX_COLS;
    localparam int CELL_IDX_BITS = $clog2(CELL_COUNT);
    localparam int ROW_BITS      = $clog2(MAX_ROWS);
    localparam int COL_BITS      = $clog2(MAX_COLS);
    localparam int GRID_BITS     = 5;
    localparam int CENTER_BITS   = COORD_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y    = 3'd5;

    // Operation modes
    localparam logic [1:0] MODE_QUERY  = 2'd0;
    localparam logic [1:0] MODE_OCCUPY = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;
    localparam logic [1:0] MODE_CENTER = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [ROW_BITS-1:0]   cell_row;
        logic [COL_BITS-1:0]   cell_col;
    } in_t;

    typedef struct packed {
        logic [CELL_IDX_BITS-1:0] cell_index;
        logic                     occupied;
        logic [CENTER_BITS-1:0]   center_x;
        logic [CENTER_BITS-1:0]   center_y;
        logic                     out_of_range;
    } out_t;

endpackage

/* rtl/core/grid_cell_occupancy_map_unit.sv */
// Top level of the grid cell occupancy map unit: sequencer, shared divider, store.
`timescale 1ns / 1ps
`include "grid_cell_occupancy_map_unit_assert.svh"

// Usage:
//   Command channel: drive item and raise start; the word is taken at the clock
//   edge where start is high and busy is low. busy stays high until the result
//   has been issued; one word at a time.
//   Result channel: done pulses for one cycle with the word on result. The
//   receiver cannot stall, so results are issued as soon as they are ready.
//   Config port: cfg_we/cfg_index/cfg_data write a register; indexes past
//   origin_y are ignored. Write only while idle.
// Steps from start accept to done, cell center: check, multiply, read, result;
//   point modes: check, divide x, divide y, range check, multiply, read, result;
//   flagged words finish early. A word after reset or a config write to a
//   register first recomputes cell width and height. Each division uses one
//   shared restoring divider at two quotient bits per cycle.
// Reset: registers return to 640x480, 5 rows, 9 cols, origin 0. The occupancy
//   RAM is then cleared one cell a cycle, all 256 cells, with busy held high.
module grid_cell_occupancy_map_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  gcom_pkg::in_t                item,
    output logic                         busy,
    output logic                         done,
    output gcom_pkg::out_t               result,
    input  logic                         cfg_we,
    input  logic [gcom_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gcom_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    import gcom_pkg::*;

    localparam int DIV_STEPS = COORD_BITS / 2;
    localparam int DCNT_BITS = $clog2(DIV_STEPS);
    localparam int PROD_BITS = COORD_BITS + ROW_BITS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_GEOW  = 4'd2;
    localparam logic [3:0] S_GEOH  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_DIVX  = 4'd5;
    localparam logic [3:0] S_DIVY  = 4'd6;
    localparam logic [3:0] S_RANGE = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_READ  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [2*COORD_BITS-1:0] div_step(
        input logic [COORD_BITS-1:0] rem,
        input logic [COORD_BITS-1:0] quo,
        input logic [COORD_BITS-1:0] den
    );
        logic [COORD_BITS:0] t;
        logic [COORD_BITS:0] diff;
        logic                fit;
        t    = {rem, quo[COORD_BITS-1]};
        diff = t - {1'b0, den};
        fit  = (t >= {1'b0, den});
        return {fit ? diff[COORD_BITS-1:0] : t[COORD_BITS-1:0],
                quo[COORD_BITS-2:0], fit};
    endfunction

    // Configuration registers
    logic [COORD_BITS-1:0] area_width_reg, area_height_reg;
    logic [COORD_BITS-1:0] origin_x_reg, origin_y_reg;
    logic [GRID_BITS-1:0]  grid_rows_reg, grid_cols_reg;
    logic                  geom_dirty_reg;

    // Sequencer and datapath
    logic [3:0]               state_reg, state_next;
    logic [CELL_IDX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    in_t                      item_reg, item_next;
    logic [COORD_BITS-1:0]    cw_reg, cw_next, ch_reg, ch_next;
    logic [COORD_BITS-1:0]    div_rem_reg, div_rem_next;
    logic [COORD_BITS-1:0]    div_quo_reg, div_quo_next;
    logic [COORD_BITS-1:0]    div_den_reg, div_den_next;
    logic [DCNT_BITS-1:0]     div_cnt_reg, div_cnt_next;
    logic [COORD_BITS-1:0]    col_full_reg, col_full_next;
    logic [ROW_BITS-1:0]      row_reg, row_next;
    logic [COL_BITS-1:0]      col_reg, col_next;
    logic [CELL_IDX_BITS-1:0] idx_reg, idx_next;
    logic [CENTER_BITS-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic                     done_reg, done_next;
    out_t                     result_reg, result_next;
    logic                     geom_clean;

    logic [2*COORD_BITS-1:0]  step1, step2;
    logic [COORD_BITS-1:0]    div_out_rem, div_out_quo;
    logic                     div_last;
    logic                     geo_bad;
    logic [PROD_BITS-1:0]     prod_x, prod_y;
    logic [2*GRID_BITS-1:0]   prod_idx;

    logic                     ram_we, ram_wdata, ram_rdata;
    logic [CELL_IDX_BITS-1:0] ram_waddr;

    // Shared divider: two quotient bits per cycle
    assign step1       = div_step(div_rem_reg, div_quo_reg, div_den_reg);
    assign step2       = div_step(step1[2*COORD_BITS-1:COORD_BITS],
                                  step1[COORD_BITS-1:0], div_den_reg);
    assign div_out_rem = step2[2*COORD_BITS-1:COORD_BITS];
    assign div_out_quo = step2[COORD_BITS-1:0];
    assign div_last    = (div_cnt_reg == DCNT_BITS'(DIV_STEPS - 1));

    assign geo_bad = (grid_rows_reg == '0) || (grid_cols_reg == '0) ||
                     (grid_rows_reg > GRID_BITS'(MAX_ROWS)) ||
                     (grid_cols_reg > GRID_BITS'(MAX_COLS)) ||
                     (cw_reg == '0) || (ch_reg == '0);

    assign prod_x   = col_reg * cw_reg;
    assign prod_y   = row_reg * ch_reg;
    assign prod_idx = {{(GRID_BITS-ROW_BITS){1'b0}}, row_reg} * grid_cols_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        item_next     = item_reg;
        cw_next       = cw_reg;
        ch_next       = ch_reg;
        div_rem_next  = div_out_rem;
        div_quo_next  = div_out_quo;
        div_den_next  = div_den_reg;
        div_cnt_next  = div_cnt_reg + 1'b1;
        col_full_next = col_full_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        idx_next      = idx_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        geom_clean    = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CELL_IDX_BITS'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    if (geom_dirty_reg)
                    begin
                        div_rem_next = '0;
                        div_quo_next = area_width_reg;
                        div_den_next = COORD_BITS'(grid_cols_reg);
                        div_cnt_next = '0;
                        state_next   = S_GEOW;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_GEOW:
            begin
                if (div_last)
                begin
                    cw_next      = div_out_quo;
                    div_rem_next = '0;
                    div_quo_next = area_height_reg;
                    div_den_next = COORD_BITS'(grid_rows_reg);
                    div_cnt_next = '0;
                    state_next   = S_GEOH;
                end
            end
            S_GEOH:
            begin
                if (div_last)
                begin
                    ch_next    = div_out_quo;
                    geom_clean = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (geo_bad)
                begin
                    result_next              = '0;
                    result_next.out_of_range = 1'b1;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else if (item_reg.mode == MODE_CENTER)
                begin
                    row_next = item_reg.cell_row;
                    col_next = item_reg.cell_col;
                    if ((GRID_BITS'(item_reg.cell_row) >= grid_rows_reg) ||
                        (GRID_BITS'(item_reg.cell_col) >= grid_cols_reg))
                    begin
                        result_next              = '0;
                        result_next.out_of_range = 1'b1;
                        done_next                = 1'b1;
                        state_next               = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else if ((item_reg.point_x < origin_x_reg) ||
                         (item_reg.point_y < origin_y_reg))
                begin
                    result_next              = '0;
                    result_next.out_of_range = 1'b1;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    div_rem_next = '0;
                    div_quo_next = item_reg.point_x - origin_x_reg;
                    div_den_next = cw_reg;
                    div_cnt_next = '0;
                    state_next   = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_last)
                begin
                    col_full_next = div_out_quo;
                    div_rem_next  = '0;
                    div_quo_next  = item_reg.point_y - origin_y_reg;
                    div_den_next  = ch_reg;
                    div_cnt_next  = '0;
                    state_next    = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_last)
                begin
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                // div_quo holds the row quotient here
                if ((col_full_reg >= COORD_BITS'(grid_cols_reg)) ||
                    (div_quo_reg >= COORD_BITS'(grid_rows_reg)))
                begin
                    result_next              = '0;
                    result_next.out_of_range = 1'b1;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    row_next   = div_quo_reg[ROW_BITS-1:0];
                    col_next   = col_full_reg[COL_BITS-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                idx_next = CELL_IDX_BITS'(prod_idx + (2*GRID_BITS)'(col_reg));
                cx_next  = prod_x[CENTER_BITS-1:0] + CENTER_BITS'(cw_reg >> 1) +
                           CENTER_BITS'(origin_x_reg);
                cy_next  = prod_y[CENTER_BITS-1:0] + CENTER_BITS'(ch_reg >> 1) +
                           CENTER_BITS'(origin_y_reg);
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                result_next.cell_index   = idx_reg;
                result_next.occupied     = ram_rdata;
                result_next.out_of_range = 1'b0;
                if (item_reg.mode == MODE_CENTER)
                begin
                    result_next.center_x = cx_reg;
                    result_next.center_y = cy_reg;
                end
                else
                begin
                    result_next.center_x = '0;
                    result_next.center_y = '0;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            geom_dirty_reg  <= 1'b1;
            area_width_reg  <= COORD_BITS'(640);
            area_height_reg <= COORD_BITS'(480);
            grid_rows_reg   <= GRID_BITS'(5);
            grid_cols_reg   <= GRID_BITS'(9);
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            div_cnt_reg <= div_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AREA_WIDTH:  area_width_reg  <= cfg_data;
                    REG_AREA_HEIGHT: area_height_reg <= cfg_data;
                    REG_GRID_ROWS:   grid_rows_reg   <= cfg_data[GRID_BITS-1:0];
                    REG_GRID_COLS:   grid_cols_reg   <= cfg_data[GRID_BITS-1:0];
                    REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                    REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                    default:         ;
                endcase
            end
            // writes past the register list leave the geometry alone
            if (cfg_we && (cfg_index <= REG_ORIGIN_Y))
            begin
                geom_dirty_reg <= 1'b1;
            end
            else if (geom_clean)
            begin
                geom_dirty_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cw_reg       <= cw_next;
        ch_reg       <= ch_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        col_full_reg <= col_full_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        idx_reg      <= idx_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        result_reg   <= result_next;
    end

    // Occupancy store: cleared after reset, written on occupy and free
    assign ram_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_DONE) &&
                        ((item_reg.mode == MODE_OCCUPY) || (item_reg.mode == MODE_FREE)));
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : idx_reg;
    assign ram_wdata = (state_reg == S_DONE) && (item_reg.mode == MODE_OCCUPY);

    gcom_ram #(
        .WIDTH (1),
        .DEPTH (CELL_COUNT)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `GCOM_ASSERT_NEXT(a_done_single, done_reg, !done_reg,
        "two result words on back-to-back cycles")
    `GCOM_ASSERT_NOW(a_flagged_zero, done_reg && result_reg.out_of_range,
        (result_reg.cell_index == '0) && !result_reg.occupied &&
        (result_reg.center_x == '0) && (result_reg.center_y == '0),
        "flagged word carries nonzero fields")
    `GCOM_ASSERT_NOW(a_store_write, ram_we && (state_reg != S_CLEAR),
        (state_reg == S_DONE) && !done_reg,
        "store written outside clear pass or result cycle")

endmodule

/* rtl/core/gcom_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gcom_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
